### design/lsws_pkg.sv
package lsws_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_PIXEL_BITS     = 12;
  localparam int DEF_MAX_LINE_WIDTH = 256;

  // Headroom bits of the running mask sum over the pixel width
  localparam int SUM_GROWTH = 5;

  // Result pixel width
  localparam int OUT_BITS = 8;

  // Pixel cells in the window chain: the newest five words of the last two groups
  localparam int TAP_COUNT = 5;

  typedef enum logic [1:0] {
    WT_ZERO,
    WT_NEG,
    WT_FIVE
  } weight_t;

  // Weight of each chain cell, newest word first: right column of the old
  // window (now the center) is -1, 5, -1 and its left neighbor middle is -1
  localparam weight_t TAP_WEIGHTS [TAP_COUNT] = '{WT_NEG, WT_FIVE, WT_NEG, WT_ZERO, WT_NEG};

  typedef logic [OUT_BITS-1:0] pix_out_t;

endpackage

### design/lsws_tap_cell.sv
module lsws_tap_cell #(
  parameter int                PIXEL_BITS = lsws_pkg::DEF_PIXEL_BITS,
  parameter lsws_pkg::weight_t WEIGHT     = lsws_pkg::WT_ZERO,
  localparam int               SUM_BITS   = PIXEL_BITS + lsws_pkg::SUM_GROWTH
) (
  input  logic                  clk,
  input  logic                  shift_en,
  input  logic [PIXEL_BITS-1:0] pix_in,
  output logic [PIXEL_BITS-1:0] pix_out,
  output logic [SUM_BITS-1:0]   term
);
  import lsws_pkg::*;

  logic [PIXEL_BITS-1:0] pix_r;
  logic [SUM_BITS-1:0]   pix_ext;

  // Take pix_in (the neighbor's word, or the new input word at cell 0) on every accepted input word
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r <= pix_in;
    end
  end

  assign pix_out = pix_r;
  assign pix_ext = SUM_BITS'(pix_r);

  // Weighted contribution, modulo the sum width
  always_comb begin
    case (WEIGHT)
      WT_NEG:  term = '0 - pix_ext;
      WT_FIVE: term = (pix_ext << 2) + pix_ext;
      WT_ZERO: term = '0;
      default: term = '0;
    endcase
  end

endmodule

### design/lsws_out_buf.sv
module lsws_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lsws_pkg::pix_out_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output lsws_pkg::pix_out_t out_data
);
  import lsws_pkg::*;

  pix_out_t head_r, head_nxt;
  pix_out_t tail_r, tail_nxt;
  logic     head_v_r, head_v_nxt;
  logic     tail_v_r, tail_v_nxt;
  logic     pop;

  assign pop = head_v_r & ~out_stall;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    if (pop) begin
      if (tail_v_r) begin
        head_nxt   = tail_r;
        tail_nxt   = push_data;
        tail_v_nxt = push;
      end else begin
        head_nxt   = push_data;
        head_v_nxt = push;
      end
    end else if (push) begin
      if (head_v_r) begin
        tail_nxt   = push_data;
        tail_v_nxt = 1'b1;
      end else begin
        head_nxt   = push_data;
        head_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign full      = tail_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

endmodule

### design/laplacian_sharpen_window_stream.sv
// Streaming 3x3 sharpening filter (mask 0,-1,0 / -1,5,-1 / 0,-1,0) over a line of pixel
// columns. Each input word is one pixel; pixels arrive in groups of three (top, middle,
// bottom of one column). The first position of a line takes two groups and treats the
// column to its left as zero; every later position takes one new group. A result word,
// the mask sum clamped to 0..255, enters the output buffer as the closing word of a window is
// accepted. One input word is taken every clock cycle; the only stall comes from the
// two-word output buffer, and only on a word that closes a window while both buffer slots
// are full. The last five accepted pixels sit in a chain of cells that shifts on every
// accepted word, so the right column of one window is the center column of the next.
// cfg_wdata sets line_width, the number of positions per line (reset MAX_LINE_WIDTH);
// write it only while no word is in flight. There is no clearing pass after reset.
module laplacian_sharpen_window_stream #(
  parameter int  PIXEL_BITS     = lsws_pkg::DEF_PIXEL_BITS,
  parameter int  MAX_LINE_WIDTH = lsws_pkg::DEF_MAX_LINE_WIDTH,
  localparam int LW_BITS        = $clog2(2 * MAX_LINE_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input pixel channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [PIXEL_BITS-1:0]     in_pixel_in,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lsws_pkg::OUT_BITS-1:0] out_pixel_out,
  // configuration
  input  logic                      cfg_we,
  input  logic [LW_BITS-1:0]        cfg_wdata
);
  import lsws_pkg::*;

  localparam int SUM_BITS  = PIXEL_BITS + SUM_GROWTH;
  localparam int POS_BITS  = $clog2(MAX_LINE_WIDTH);
  localparam logic [LW_BITS-1:0] LW_MASK  = LW_BITS'(2 * MAX_LINE_WIDTH - 1);
  localparam logic [LW_BITS-1:0] LW_RESET = LW_BITS'(MAX_LINE_WIDTH) & LW_MASK;

  // Word slot within one step. The first position of a line walks all six
  // (center group, then right group); later positions use the first three
  // for the new right group.
  localparam logic [2:0] PH_G0_TOP = 3'd0;
  localparam logic [2:0] PH_G0_MID = 3'd1;
  localparam logic [2:0] PH_G0_BOT = 3'd2;
  localparam logic [2:0] PH_G1_TOP = 3'd3;
  localparam logic [2:0] PH_G1_MID = 3'd4;
  localparam logic [2:0] PH_G1_BOT = 3'd5;

  logic [LW_BITS-1:0]  lw_r, lw_nxt;
  logic [2:0]          phase_r, phase_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;

  logic                accept;
  logic                pos_first;
  logic                pos_is_last;
  logic                emit_now;
  logic [LW_BITS-1:0]  last_pos;
  logic [POS_BITS:0]   pos_inc;
  logic [POS_BITS-1:0] pos_wrap;
  logic [SUM_BITS-1:0] p_ext, p_neg, p_five;
  logic [SUM_BITS-1:0] tap_sum;
  logic [SUM_BITS-1:0] delta;
  pix_out_t            clamped;
  logic                buf_full;

  logic [PIXEL_BITS-1:0] chain [TAP_COUNT];
  logic [SUM_BITS-1:0]   terms [TAP_COUNT];

  // ---------------------------------------------------------------------------
  // Handshake. A window closes on a known slot, so the stall depends on state
  // and the buffer fill only, never on the output side in the same cycle.
  // ---------------------------------------------------------------------------
  assign pos_first = (pos_r == '0);
  assign emit_now  = pos_first ? (phase_r == PH_G1_BOT) : (phase_r == PH_G0_BOT);
  assign in_stall  = emit_now & buf_full;
  assign accept    = in_valid & ~in_stall;

  // ---------------------------------------------------------------------------
  // Pixel cell chain: cell 0 holds the newest word. At a later position's
  // first slot the chain holds the previous group and the middle and bottom
  // words of the group before it, which is all the mask needs from the past.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
    lsws_tap_cell #(
      .PIXEL_BITS (PIXEL_BITS),
      .WEIGHT     (TAP_WEIGHTS[i])
    ) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .pix_in   ((i == 0) ? in_pixel_in : chain[(i == 0) ? 0 : i - 1]),
      .pix_out  (chain[i]),
      .term     (terms[i])
    );
  end

  always_comb begin
    tap_sum = '0;
    for (int i = 0; i < TAP_COUNT; i++) begin
      tap_sum = tap_sum + terms[i];
    end
  end

  // Contribution of the word coming in now
  assign p_ext  = SUM_BITS'(in_pixel_in);
  assign p_neg  = '0 - p_ext;
  assign p_five = (p_ext << 2) + p_ext;

  // Pick what this slot adds to the running sum
  always_comb begin
    delta = '0;
    if (pos_first) begin
      unique case (phase_r) inside
        PH_G0_TOP, PH_G0_BOT, PH_G1_MID: delta = p_neg;
        PH_G0_MID:                       delta = p_five;
        default:                         delta = '0;
      endcase
    end else begin
      unique case (phase_r) inside
        PH_G0_TOP: delta = tap_sum;
        PH_G0_MID: delta = p_neg;
        default:   delta = '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Line position and slot sequencing
  // ---------------------------------------------------------------------------
  assign last_pos    = (lw_r - LW_BITS'(1)) & LW_MASK;
  assign pos_is_last = ({{(LW_BITS - POS_BITS){1'b0}}, pos_r} == last_pos);
  assign pos_inc     = {1'b0, pos_r} + (POS_BITS + 1)'(1);
  // Wrap past the largest line width back to a fresh first position
  assign pos_wrap    = (pos_inc >= (POS_BITS + 1)'(MAX_LINE_WIDTH)) ? '0
                                                                    : pos_inc[POS_BITS-1:0];

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    if (accept) begin
      // Drop the sum once it is sent, otherwise accumulate
      sum_nxt = emit_now ? '0 : sum_r + delta;
      if (phase_r == PH_G0_BOT && pos_is_last) begin
        pos_nxt   = '0;
        phase_nxt = PH_G0_TOP;
      end else if (!pos_is_last && !pos_first && phase_r == PH_G0_BOT) begin
        pos_nxt   = pos_wrap;
        phase_nxt = PH_G0_TOP;
      end else if (pos_first && phase_r == PH_G1_BOT) begin
        pos_nxt   = pos_wrap;
        phase_nxt = PH_G0_TOP;
      end else begin
        phase_nxt = phase_r + 3'd1;
      end
    end
  end

  assign lw_nxt = cfg_we ? (cfg_wdata & LW_MASK) : lw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r    <= LW_RESET;
      phase_r <= PH_G0_TOP;
      pos_r   <= '0;
      sum_r   <= '0;
    end else begin
      lw_r    <= lw_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Clamp the signed sum to 0..255 and hand it to the output buffer
  // ---------------------------------------------------------------------------
  always_comb begin
    if (sum_r[SUM_BITS-1]) begin
      clamped = '0;
    end else if (|sum_r[SUM_BITS-2:OUT_BITS]) begin
      clamped = '1;
    end else begin
      clamped = sum_r[OUT_BITS-1:0];
    end
  end

  lsws_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept & emit_now),
    .push_data (clamped),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_pixel_out)
  );

endmodule

### sim/tb_laplacian_sharpen_window_stream.sv
`timescale 1ns / 100ps

module tb_laplacian_sharpen_window_stream;

  import lsws_pkg::*;

  localparam int PIX_W   = DEF_PIXEL_BITS;
  localparam int MAX_W   = DEF_MAX_LINE_WIDTH;
  localparam int LW_W    = $clog2(2 * MAX_W);
  localparam int POS_W   = $clog2(MAX_W);
  localparam int SUM_W   = PIX_W + SUM_GROWTH;
  localparam int PIX_MAX = (1 << PIX_W) - 1;

  // Cycles from a closing word to its result word, plus the output buffer
  localparam int DRAIN_CYCLES = 4;

  // Directed table: pixel word, and the result typed in where it is obvious
  typedef struct packed {
    logic [PIX_W-1:0]    px;
    logic                known;
    logic [OUT_BITS-1:0] want;
  } dir_row_t;

  localparam int DIR_COUNT = 27;

  // Width 2: each line is a first window (six words) and one closing column.
  // Line A: full scale but for the closing column's top and bottom, clamps high.
  // Line B: small values, unclamped sum; the unweighted words are full scale.
  // Line C: center middle dark, neighbors bright, clamps low.
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{12'd4095, 1'b0, 8'd0}, '{12'd4095, 1'b0, 8'd0}, '{12'd4095, 1'b0, 8'd0},
    '{12'd4095, 1'b0, 8'd0}, '{12'd4095, 1'b0, 8'd0}, '{12'd4095, 1'b1, 8'd255},
    '{12'd0,    1'b0, 8'd0}, '{12'd4095, 1'b0, 8'd0}, '{12'd0,    1'b0, 8'd0},
    '{12'd10,   1'b0, 8'd0}, '{12'd60,   1'b0, 8'd0}, '{12'd20,   1'b0, 8'd0},
    '{12'd4095, 1'b0, 8'd0}, '{12'd30,   1'b0, 8'd0}, '{12'd4095, 1'b1, 8'd240},
    '{12'd4095, 1'b0, 8'd0}, '{12'd4095, 1'b0, 8'd0}, '{12'd4095, 1'b0, 8'd0},
    '{12'd4095, 1'b0, 8'd0}, '{12'd0,    1'b0, 8'd0}, '{12'd4095, 1'b0, 8'd0},
    '{12'd0,    1'b0, 8'd0}, '{12'd4095, 1'b0, 8'd0}, '{12'd0,    1'b1, 8'd0},
    '{12'd0,    1'b0, 8'd0}, '{12'd0,    1'b0, 8'd0}, '{12'd0,    1'b0, 8'd0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PIX_W-1:0]    in_pixel_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OUT_BITS-1:0] out_pixel_out;
  logic                cfg_we = 1'b0;
  logic [LW_W-1:0]     cfg_wdata = '0;

  laplacian_sharpen_window_stream #(
    .PIXEL_BITS     (PIX_W),
    .MAX_LINE_WIDTH (MAX_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor: its own copy of the kept columns, running mask sum,
  // word phase inside the current step and column position along the line.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] col_store [6];
  logic [SUM_W-1:0] mask_sum;
  logic [2:0]       pix_phase;
  logic [POS_W-1:0] col_pos;
  logic [LW_W-1:0]  width_reg;

  logic [OUT_BITS-1:0] expected_pixels [$];

  int err_count      = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int widths_written = 0;

  function automatic void clear_columns();
    for (int i = 0; i < 6; i++) col_store[i] = '0;
  endfunction

  function automatic void sharpen_reset();
    clear_columns();
    mask_sum  = '0;
    pix_phase = '0;
    col_pos   = '0;
    width_reg = LW_W'(MAX_W);
  endfunction

  // Advance the predictor by one pixel word; flag and return a result word
  // when this word closes a window.
  function automatic void sharpen_step(input logic [PIX_W-1:0] px,
                                       output bit fire,
                                       output logic [OUT_BITS-1:0] res);
    logic [LW_W-1:0]         last_pos;
    logic [LW_W-1:0]         pos_ext;
    logic [PIX_W-1:0]        tmp;
    logic signed [SUM_W-1:0] sum_s;
    logic [SUM_W-1:0]        px_ext;
    last_pos = width_reg - LW_W'(1);
    pos_ext  = LW_W'(col_pos);
    px_ext   = SUM_W'(px);
    fire     = 1'b0;
    res      = '0;
    if (col_pos == '0) begin
      // First position: center column gets -1, 5, -1, right column 0, -1, 0
      case (pix_phase)
        3'd0: begin mask_sum = mask_sum - px_ext; col_store[0] = px; end
        3'd1: begin mask_sum = mask_sum + px_ext * SUM_W'(5); col_store[1] = px; end
        3'd2: begin mask_sum = mask_sum - px_ext; col_store[2] = px; end
        3'd3: col_store[3] = px;
        3'd4: begin mask_sum = mask_sum - px_ext; col_store[4] = px; end
        3'd5: begin col_store[5] = px; fire = 1'b1; end
        default: ;
      endcase
    end else begin
      // Later positions: fold in the kept columns on the first word, then the
      // new right column's middle word
      case (pix_phase)
        3'd0: begin
          mask_sum = mask_sum - SUM_W'(col_store[1]);
          mask_sum = mask_sum - SUM_W'(col_store[3]);
          mask_sum = mask_sum + SUM_W'(col_store[4]) * SUM_W'(5);
          mask_sum = mask_sum - SUM_W'(col_store[5]);
          col_store[0] = px;
        end
        3'd1: begin mask_sum = mask_sum - px_ext; col_store[1] = px; end
        3'd2: begin col_store[2] = px; fire = 1'b1; end
        default: ;
      endcase
    end

    if (fire) begin
      sum_s = $signed(mask_sum);
      if (sum_s > $signed(SUM_W'(255))) res = 8'd255;
      else if (sum_s < 0) res = '0;
      else res = sum_s[OUT_BITS-1:0];
      mask_sum = '0;
    end

    if (pix_phase == 3'd2 && pos_ext == last_pos) begin
      // End of line: restart at the first position with empty columns
      col_pos   = '0;
      pix_phase = '0;
      clear_columns();
    end else if (pos_ext != last_pos && col_pos != '0 && pix_phase == 3'd2) begin
      // Slide: the new column becomes the center, the old center the left
      col_pos   = (col_pos == POS_W'(MAX_W - 1)) ? '0 : col_pos + POS_W'(1);
      pix_phase = '0;
      for (int i = 0; i < 3; i++) begin
        tmp              = col_store[i];
        col_store[i]     = col_store[i + 3];
        col_store[i + 3] = tmp;
      end
    end else if (col_pos == '0 && pix_phase == 3'd5) begin
      col_pos   = POS_W'(1);
      pix_phase = '0;
    end else begin
      pix_phase = pix_phase + 3'd1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                 input logic [OUT_BITS-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: draw a stall stretch after every accepted result word, with
  // calm stretches where the receiver never stalls.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  bit          recv_calm  = 1'b0;

  always @(posedge clk) begin
    logic [OUT_BITS-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          report_mismatch("result word with nothing expected", out_pixel_out, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_out !== want)
            report_mismatch("pixel_out", out_pixel_out, want);
        end
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, 16);
      end
      // Hold stall for the drawn stretch, then release
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  bit send_calm = 1'b0;
  logic [PIX_W-1:0] flat_level = '0;

  // Present one pixel word after a random gap, hold it until accepted, then
  // advance the predictor. A typed-in result replaces the predicted one.
  task automatic send_word(input logic [PIX_W-1:0] px, input bit known,
                           input logic [OUT_BITS-1:0] want);
    int gap;
    bit fire;
    logic [OUT_BITS-1:0] res;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    sharpen_step(px, fire, res);
    if (fire) expected_pixels.push_back(known ? want : res);
  endtask

  // Mix of extremes, near-flat areas (where the sum lands around 0..255)
  // and full-range noise.
  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 15);
    if ($urandom_range(0, 40) == 0) flat_level = PIX_W'($urandom_range(0, 280));
    if (r == 0) return '0;
    if (r == 1) return PIX_W'(PIX_MAX);
    if (r < 9) return flat_level + PIX_W'($urandom_range(0, 8));
    return PIX_W'($urandom_range(0, PIX_MAX));
  endfunction

  // Write line_width with the block idle: drop valid, drain every expected
  // result, let a word that caused none settle, then pulse the write enable.
  task automatic write_width(input logic [LW_W-1:0] w);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg = w;
    widths_written++;
  endtask

  // Send a burst of random words at one width; optionally keep going until
  // the line wraps back to its first position.
  task automatic run_phase(input logic [LW_W-1:0] w, input int count, input bit finish_line);
    write_width(w);
    for (int i = 0; i < count; i++) send_word(pick_pixel(), 1'b0, '0);
    if (finish_line)
      while (col_pos != '0 || pix_phase != '0) send_word(pick_pixel(), 1'b0, '0);
  endtask

  initial begin
    sharpen_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: shortest lines that close a window, known windows at and between the extremes
    write_width(LW_W'(2));
    for (int i = 0; i < DIR_COUNT; i++)
      send_word(DIR_ROWS[i].px, DIR_ROWS[i].known, DIR_ROWS[i].want);

    // Widest line, stopped mid-line; then lower the width below the current
    // position so the position runs on until it wraps without a clear
    run_phase(LW_W'(MAX_W), 60, 1'b0);
    run_phase(LW_W'(5), 20, 1'b1);
    // Width one never closes a window; the sum keeps growing and wraps, and
    // carries into the first window after the next write
    run_phase(LW_W'(1), 45, 1'b1);
    run_phase(LW_W'(2), 18, 1'b1);
    run_phase(LW_W'($urandom_range(3, 12)), 20, 1'b1);
    run_phase(LW_W'($urandom_range(3, 12)), 20, 1'b1);
    // Widths whose last position is never reached
    run_phase(LW_W'(0), 10, 1'b0);
    run_phase(LW_W'(2 * MAX_W - 1), 10, 1'b0);
    run_phase(LW_W'($urandom_range(MAX_W + 1, 2 * MAX_W - 2)), 10, 1'b0);
    in_valid <= 1'b0;

    // Drain and let the pipeline settle
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);

    $display("Sent %0d pixel words and checked %0d result words", words_sent, results_seen);
    $display("Line width written %0d times, covering 0, 1, 2, max and wrapping widths",
             widths_written);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout with %0d result words still expected", expected_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
design/lsws_pkg.sv
design/lsws_tap_cell.sv
design/lsws_out_buf.sv
design/laplacian_sharpen_window_stream.sv
sim/tb_laplacian_sharpen_window_stream.sv
